/* src/rsi_pkg.sv */
// ----------------------------------------------------------------------------
// rsi_pkg
// Types, codes and constants shared by the radix string-to-integer parser.
// ----------------------------------------------------------------------------
package rsi_pkg;

  localparam int CHAR_W     = 8;
  localparam int COUNT_W    = 16;
  localparam int RADIX_W    = 6;
  localparam int MODE_W     = 2;
  localparam int DIGIT_W    = 6;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 8;

  // register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_RADIX       = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_MINUS_CHAR  = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_PLUS_CHAR   = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_FILL_CHAR   = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_FILL_MODE   = 3'd4;
  localparam logic [CFG_IDX_W-1:0] CFG_LETTER_CASE = 3'd5;

  // fill modes; any other code skips no fill
  localparam logic [MODE_W-1:0] FM_LEFT     = 2'd0;
  localparam logic [MODE_W-1:0] FM_INTERNAL = 2'd1;

  // letter case codes; the unused code behaves as upper
  localparam logic [MODE_W-1:0] LC_LOWER = 2'd0;
  localparam logic [MODE_W-1:0] LC_MIXED = 2'd2;

  // reset values
  localparam logic [RADIX_W-1:0] RADIX_RESET       = 6'd10;
  localparam logic [CHAR_W-1:0]  MINUS_RESET       = 8'd45;
  localparam logic [CHAR_W-1:0]  PLUS_RESET        = 8'd43;
  localparam logic [CHAR_W-1:0]  FILL_RESET        = 8'd0;
  localparam logic [MODE_W-1:0]  FILL_MODE_RESET   = 2'd0;
  localparam logic [MODE_W-1:0]  LETTER_CASE_RESET = 2'd2;

  localparam logic [RADIX_W-1:0] RADIX_MIN = 6'd2;
  localparam logic [RADIX_W-1:0] RADIX_MAX = 6'd36;
  localparam logic [RADIX_W-1:0] RADIX_DEC = 6'd10;

  localparam logic [CHAR_W-1:0] CHAR_ZERO    = 8'd48;
  localparam logic [CHAR_W-1:0] CHAR_NINE    = 8'd57;
  localparam logic [CHAR_W-1:0] CHAR_UPPER_A = 8'd65;
  localparam logic [CHAR_W-1:0] CHAR_LOWER_A = 8'd97;
  localparam logic [CHAR_W-1:0] UPPER_OFS    = 8'd55;
  localparam logic [CHAR_W-1:0] LOWER_OFS    = 8'd87;

  localparam logic [CHAR_W-1:0]  CHAR_NONE = 8'd0;
  localparam logic [COUNT_W-1:0] COUNT_MAX = 16'hFFFF;

  typedef enum logic [3:0] {
    PH_LFILL  = 4'b0001,
    PH_IFILL  = 4'b0010,
    PH_DIGITS = 4'b0100,
    PH_DONE   = 4'b1000
  } phase_t;

  typedef struct packed {
    logic [MODE_W-1:0] fill_mode;
    logic [MODE_W-1:0] letter_case;
    logic [RADIX_W-1:0] radix;
    logic [CHAR_W-1:0]  minus_char;
    logic [CHAR_W-1:0]  plus_char;
    logic [CHAR_W-1:0]  fill_char;
  } cfg_t;

  typedef struct packed {
    logic               lfill_hit;
    logic               ifill_hit;
    logic               minus_hit;
    logic               plus_hit;
    logic               digit_ok;
    logic [DIGIT_W-1:0] digit_val;
    logic [RADIX_W-1:0] base;
  } char_class_t;

endpackage

/* src/rsi_if.sv */
// ----------------------------------------------------------------------------
// rsi_in_if / rsi_out_if
// Valid/ready channels for characters in and parse results out.
// ----------------------------------------------------------------------------
interface rsi_in_if;
  import rsi_pkg::*;

  logic              valid;
  logic              ready;
  logic [CHAR_W-1:0] char_code;
  logic              begin_req;

  modport source (output valid, output char_code, output begin_req, input ready);
  modport sink   (input valid, input char_code, input begin_req, output ready);
endinterface

interface rsi_out_if #(parameter int VALUE_WIDTH = 64);
  import rsi_pkg::*;

  logic                   valid;
  logic                   ready;
  logic [VALUE_WIDTH-1:0] parsed_value;
  logic [COUNT_W-1:0]     consumed_count;
  logic                   saw_minus;

  modport source (output valid, output parsed_value, output consumed_count,
                  output saw_minus, input ready);
  modport sink   (input valid, input parsed_value, input consumed_count,
                  input saw_minus, output ready);
endinterface

/* src/rsi_char_class.sv */
// ----------------------------------------------------------------------------
// rsi_char_class
// Classifies one character against the configuration: fill, sign, digit.
// ----------------------------------------------------------------------------
module rsi_char_class (
  input  logic [rsi_pkg::CHAR_W-1:0] char_code,
  input  rsi_pkg::cfg_t              cfg,
  output rsi_pkg::char_class_t       cls
);
  import rsi_pkg::*;

  logic [RADIX_W-1:0] base;
  logic               fill_on;
  logic               low_ok;
  logic               up_ok;
  logic [CHAR_W:0]    c_ext;
  logic [CHAR_W:0]    dec_lim;
  logic [CHAR_W:0]    up_lim;
  logic [CHAR_W:0]    low_lim;
  logic [DIGIT_W-1:0] dval;
  logic               dok;

  always_comb begin
    if (cfg.radix < RADIX_MIN) begin
      base = RADIX_MIN;
    end else if (cfg.radix > RADIX_MAX) begin
      base = RADIX_MAX;
    end else begin
      base = cfg.radix;
    end
  end

  assign fill_on = (cfg.fill_char != CHAR_NONE);
  assign low_ok  = (cfg.letter_case == LC_LOWER) || (cfg.letter_case == LC_MIXED);
  assign up_ok   = (cfg.letter_case != LC_LOWER);

  // limits kept one bit wider so the sums cannot wrap
  assign c_ext   = {1'b0, char_code};
  assign dec_lim = {1'b0, CHAR_ZERO} + (CHAR_W+1)'(base);
  assign up_lim  = {1'b0, UPPER_OFS} + (CHAR_W+1)'(base);
  assign low_lim = {1'b0, LOWER_OFS} + (CHAR_W+1)'(base);

  always_comb begin
    dok  = 1'b0;
    dval = '0;
    if (base <= RADIX_DEC) begin
      if (char_code >= CHAR_ZERO && c_ext < dec_lim) begin
        dok  = 1'b1;
        dval = DIGIT_W'(char_code - CHAR_ZERO);
      end
    end else if (char_code >= CHAR_ZERO && char_code <= CHAR_NINE) begin
      dok  = 1'b1;
      dval = DIGIT_W'(char_code - CHAR_ZERO);
    end else if (up_ok && char_code >= CHAR_UPPER_A && c_ext < up_lim) begin
      dok  = 1'b1;
      dval = DIGIT_W'(char_code - UPPER_OFS);
    end else if (low_ok && char_code >= CHAR_LOWER_A && c_ext < low_lim) begin
      dok  = 1'b1;
      dval = DIGIT_W'(char_code - LOWER_OFS);
    end
  end

  always_comb begin
    cls.lfill_hit = fill_on && (cfg.fill_mode == FM_LEFT) && (char_code == cfg.fill_char);
    cls.ifill_hit = fill_on && (cfg.fill_mode == FM_INTERNAL)
                    && (char_code == cfg.fill_char);
    cls.minus_hit = (cfg.minus_char != CHAR_NONE) && (char_code == cfg.minus_char);
    cls.plus_hit  = (cfg.plus_char != CHAR_NONE) && (char_code == cfg.plus_char);
    cls.digit_ok  = dok;
    cls.digit_val = dval;
    cls.base      = base;
  end

endmodule

/* src/radix_string_to_integer_top.sv */
// ----------------------------------------------------------------------------
// radix_string_to_integer_top
// Character-stream parser into an unsigned integer of a configured base.
// ----------------------------------------------------------------------------
// A terminating character's result goes through the input register, then
//   the result register, before it appears on the output channel.
// Throughput: one character per cycle while the result channel is not
//   stalled; the parse state loop is one multiply by the base and one add.
// Reset: synchronous; configuration returns to its defaults and the first
//   character after reset starts a new string.
module radix_string_to_integer_top #(
  parameter int VALUE_WIDTH = 64
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           cfg_wr_en,
  input  logic [rsi_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [rsi_pkg::CFG_DATA_W-1:0] cfg_data,
  rsi_in_if.sink                         in_chan,
  rsi_out_if.source                      out_chan
);
  import rsi_pkg::*;

  cfg_t cfg;

  // input register
  logic              s1_valid;
  logic [CHAR_W-1:0] s1_char;
  logic              s1_begin;

  // parse state
  phase_t                 phase, phase_next;
  logic                   neg, neg_next;
  logic [VALUE_WIDTH-1:0] acc, acc_next;
  logic [COUNT_W-1:0]     cnt, cnt_next;

  // result register
  logic                   out_valid;
  logic [VALUE_WIDTH-1:0] out_value;
  logic [COUNT_W-1:0]     out_count;
  logic                   out_minus;

  char_class_t            cls;
  logic                   advance;
  logic                   fire;
  logic                   emit;
  logic                   consume;
  logic                   at_sign;
  phase_t                 ph0;
  logic                   neg0;
  logic [VALUE_WIDTH-1:0] acc0;
  logic [COUNT_W-1:0]     cnt0;
  logic [VALUE_WIDTH-1:0] prod;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.radix       <= RADIX_RESET;
      cfg.minus_char  <= MINUS_RESET;
      cfg.plus_char   <= PLUS_RESET;
      cfg.fill_char   <= FILL_RESET;
      cfg.fill_mode   <= FILL_MODE_RESET;
      cfg.letter_case <= LETTER_CASE_RESET;
    end else if (cfg_wr_en) begin
      case (cfg_index)
        CFG_RADIX:       cfg.radix       <= cfg_data[RADIX_W-1:0];
        CFG_MINUS_CHAR:  cfg.minus_char  <= cfg_data;
        CFG_PLUS_CHAR:   cfg.plus_char   <= cfg_data;
        CFG_FILL_CHAR:   cfg.fill_char   <= cfg_data;
        CFG_FILL_MODE:   cfg.fill_mode   <= cfg_data[MODE_W-1:0];
        CFG_LETTER_CASE: cfg.letter_case <= cfg_data[MODE_W-1:0];
        default: ;
      endcase
    end
  end

  assign advance       = !out_valid || out_chan.ready;
  assign in_chan.ready = !s1_valid || advance;
  assign fire          = s1_valid && advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (in_chan.ready) begin
      s1_valid <= in_chan.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_chan.ready && in_chan.valid) begin
      s1_char  <= in_chan.char_code;
      s1_begin <= in_chan.begin_req;
    end
  end

  rsi_char_class u_class (
    .char_code (s1_char),
    .cfg       (cfg),
    .cls       (cls)
  );

  // begin restarts the string with this character
  assign ph0  = s1_begin ? PH_LFILL : phase;
  assign neg0 = s1_begin ? 1'b0 : neg;
  assign acc0 = s1_begin ? '0 : acc;
  assign cnt0 = s1_begin ? '0 : cnt;

  // only the low bits survive the wrap, the base is at most 6 bits
  assign prod = acc0 * VALUE_WIDTH'(cls.base);

  always_comb begin
    phase_next = ph0;
    neg_next   = neg0;
    acc_next   = acc0;
    emit       = 1'b0;
    consume    = 1'b0;
    at_sign    = (ph0 == PH_LFILL);
    if (ph0 != PH_DONE) begin
      if (at_sign && cls.lfill_hit) begin
        consume = 1'b1;
      end else if (at_sign && cls.minus_hit) begin
        consume    = 1'b1;
        neg_next   = 1'b1;
        phase_next = PH_IFILL;
      end else if (at_sign && cls.plus_hit) begin
        consume    = 1'b1;
        phase_next = PH_IFILL;
      end else if ((at_sign || ph0 == PH_IFILL) && cls.ifill_hit) begin
        consume    = 1'b1;
        phase_next = PH_IFILL;
      end else if (cls.digit_ok) begin
        consume    = 1'b1;
        acc_next   = prod + VALUE_WIDTH'(cls.digit_val);
        phase_next = PH_DIGITS;
      end else begin
        emit       = 1'b1;
        phase_next = PH_DONE;
      end
    end
    cnt_next = (consume && cnt0 != COUNT_MAX) ? cnt0 + 1'b1 : cnt0;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase <= PH_LFILL;
      neg   <= 1'b0;
      acc   <= '0;
      cnt   <= '0;
    end else if (fire) begin
      phase <= phase_next;
      neg   <= neg_next;
      acc   <= acc_next;
      cnt   <= cnt_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (fire && emit) begin
      out_valid <= 1'b1;
    end else if (out_chan.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (fire && emit) begin
      out_value <= neg0 ? (~acc0 + 1'b1) : acc0;
      out_count <= cnt0;
      out_minus <= neg0;
    end
  end

  assign out_chan.valid          = out_valid;
  assign out_chan.parsed_value   = out_value;
  assign out_chan.consumed_count = out_count;
  assign out_chan.saw_minus      = out_minus;

endmodule

/* sim/testbench.sv */
// ----------------------------------------------------------------------------
// testbench
// Drives character strings into the radix string-to-integer parser through
// random stalls on both channels. Each accepted character runs through a
// local model of the parse, and each result is checked against the oldest
// predicted one. Several configurations are covered: bases at and past their
// limits, every fill mode and letter case, disabled signs, and saturation of
// the consumed count.
// ----------------------------------------------------------------------------
module testbench;
  timeunit 1ns;
  timeprecision 1ps;
  import rsi_pkg::*;

  localparam int VALUE_WIDTH  = 64;
  localparam int DRAIN_CYCLES = 8;
  localparam int SAT_LENGTH   = 65540;
  localparam int IDLE_PCT     = 14;
  localparam int MAX_REPORTS  = 10;

  // codes the package leaves unnamed
  localparam logic [MODE_W-1:0] FM_NO_SKIP = 2'd2;
  localparam logic [MODE_W-1:0] FM_UNUSED  = 2'd3;
  localparam logic [MODE_W-1:0] LC_UPPER   = 2'd1;
  localparam logic [MODE_W-1:0] LC_UNUSED  = 2'd3;

  typedef enum logic [2:0] {
    P_LEAD_FILL,
    P_SIGN,
    P_INNER_FILL,
    P_DIGITS,
    P_DONE
  } parse_phase_t;

  typedef struct packed {
    logic [VALUE_WIDTH-1:0] value;
    logic [COUNT_W-1:0]     count;
    logic                   minus;
  } parse_result_t;

  logic                  clk;
  logic                  rst;
  logic                  cfg_wr_en;
  logic [CFG_IDX_W-1:0]  cfg_index;
  logic [CFG_DATA_W-1:0] cfg_data;

  rsi_in_if in_chan ();
  rsi_out_if #(.VALUE_WIDTH(VALUE_WIDTH)) out_chan ();

  radix_string_to_integer_top #(.VALUE_WIDTH(VALUE_WIDTH)) dut (
    .clk       (clk),
    .rst       (rst),
    .cfg_wr_en (cfg_wr_en),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .in_chan   (in_chan),
    .out_chan  (out_chan)
  );

  // parse model state
  cfg_t                   shadow_cfg;
  parse_phase_t           parse_phase;
  logic                   neg_seen;
  logic [VALUE_WIDTH-1:0] accum;
  logic [COUNT_W-1:0]     taken_count;
  parse_result_t          expected_results[$];

  int   chars_parsed;
  int   error_count;
  int   in_idle_pct;
  int   out_stall_pct;
  logic start_next;

  always begin
    clk = 1'b0;
    #5;
    clk = 1'b1;
    #5;
  end

  function automatic cfg_t make_cfg(int rdx, int minus, int plus, int fill, int mode, int lc);
    cfg_t c;
    c.radix       = rdx[RADIX_W-1:0];
    c.minus_char  = minus[CHAR_W-1:0];
    c.plus_char   = plus[CHAR_W-1:0];
    c.fill_char   = fill[CHAR_W-1:0];
    c.fill_mode   = mode[MODE_W-1:0];
    c.letter_case = lc[MODE_W-1:0];
    return c;
  endfunction

  function automatic int active_base();
    int r;
    r = shadow_cfg.radix;
    if (r < RADIX_MIN) r = RADIX_MIN;
    if (r > RADIX_MAX) r = RADIX_MAX;
    return r;
  endfunction

  function automatic bit digit_value(logic [CHAR_W-1:0] c, output int d);
    int ci;
    int base;
    bit low_ok;
    bit up_ok;
    ci     = c;
    base   = active_base();
    low_ok = (shadow_cfg.letter_case == LC_LOWER) || (shadow_cfg.letter_case == LC_MIXED);
    up_ok  = shadow_cfg.letter_case != LC_LOWER;
    d      = 0;
    if (base <= RADIX_DEC) begin
      if (ci >= CHAR_ZERO && ci < CHAR_ZERO + base) begin
        d = ci - CHAR_ZERO;
        return 1'b1;
      end
      return 1'b0;
    end
    if (ci >= CHAR_ZERO && ci <= CHAR_NINE) begin
      d = ci - CHAR_ZERO;
      return 1'b1;
    end
    if (up_ok && ci >= CHAR_UPPER_A && ci < UPPER_OFS + base) begin
      d = ci - UPPER_OFS;
      return 1'b1;
    end
    if (low_ok && ci >= CHAR_LOWER_A && ci < LOWER_OFS + base) begin
      d = ci - LOWER_OFS;
      return 1'b1;
    end
    return 1'b0;
  endfunction

  function automatic void restart_parse();
    parse_phase = P_LEAD_FILL;
    neg_seen    = 1'b0;
    accum       = '0;
    taken_count = '0;
  endfunction

  function automatic void count_char();
    if (taken_count != COUNT_MAX) taken_count++;
  endfunction

  // Advances the parse by one character; returns 0 if the character is ignored.
  function automatic bit parse_char(logic [CHAR_W-1:0] c, logic start);
    int            d;
    bit            fill_on;
    parse_result_t r;
    fill_on = shadow_cfg.fill_char != CHAR_NONE;
    if (start) restart_parse();
    if (parse_phase == P_DONE) return 1'b0;
    if (parse_phase == P_LEAD_FILL) begin
      if (fill_on && shadow_cfg.fill_mode == FM_LEFT && c == shadow_cfg.fill_char) begin
        count_char();
        return 1'b1;
      end
      parse_phase = P_SIGN;
    end
    if (parse_phase == P_SIGN) begin
      parse_phase = P_INNER_FILL;
      if (shadow_cfg.minus_char != CHAR_NONE && c == shadow_cfg.minus_char) begin
        neg_seen = 1'b1;
        count_char();
        return 1'b1;
      end
      if (shadow_cfg.plus_char != CHAR_NONE && c == shadow_cfg.plus_char) begin
        count_char();
        return 1'b1;
      end
    end
    if (parse_phase == P_INNER_FILL) begin
      if (fill_on && shadow_cfg.fill_mode == FM_INTERNAL && c == shadow_cfg.fill_char) begin
        count_char();
        return 1'b1;
      end
      parse_phase = P_DIGITS;
    end
    if (digit_value(c, d)) begin
      accum = accum * VALUE_WIDTH'(active_base()) + VALUE_WIDTH'(d);
      count_char();
      return 1'b1;
    end
    // terminator
    r.value = neg_seen ? -accum : accum;
    r.count = taken_count;
    r.minus = neg_seen;
    expected_results.push_back(r);
    parse_phase = P_DONE;
    return 1'b1;
  endfunction

  function automatic logic [CHAR_W-1:0] digit_char(int v);
    if (v < 10) return CHAR_W'(CHAR_ZERO + v);
    if (shadow_cfg.letter_case == LC_LOWER ||
        (shadow_cfg.letter_case == LC_MIXED && $urandom_range(1) != 0))
      return CHAR_W'(LOWER_OFS + v);
    return CHAR_W'(UPPER_OFS + v);
  endfunction

  task automatic send_char(logic [CHAR_W-1:0] c, logic start);
    while ($urandom_range(99) < in_idle_pct) begin
      in_chan.valid <= 1'b0;
      @(posedge clk);
    end
    in_chan.valid     <= 1'b1;
    in_chan.char_code <= c;
    in_chan.begin_req <= start;
    @(posedge clk);
    while (!in_chan.ready) @(posedge clk);
    if (parse_char(c, start)) chars_parsed++;
  endtask

  task automatic send_next(logic [CHAR_W-1:0] c);
    send_char(c, start_next);
    start_next = 1'b0;
  endtask

  task automatic send_text(string s, logic start);
    int i;
    for (i = 0; i < s.len(); i++) send_char(s[i], (i == 0) ? start : 1'b0);
  endtask

  task automatic send_fill_run();
    if (shadow_cfg.fill_char != CHAR_NONE && $urandom_range(2) == 0)
      repeat ($urandom_range(1, 4)) send_next(shadow_cfg.fill_char);
  endtask

  // Holds the sender until every predicted result has come out.
  task automatic wait_idle();
    in_chan.valid <= 1'b0;
    while (expected_results.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
    cfg_wr_en <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    @(posedge clk);
  endtask

  task automatic set_config(cfg_t c);
    wait_idle();
    write_reg(CFG_RADIX, CFG_DATA_W'(c.radix));
    write_reg(CFG_MINUS_CHAR, c.minus_char);
    write_reg(CFG_PLUS_CHAR, c.plus_char);
    write_reg(CFG_FILL_CHAR, c.fill_char);
    write_reg(CFG_FILL_MODE, CFG_DATA_W'(c.fill_mode));
    write_reg(CFG_LETTER_CASE, CFG_DATA_W'(c.letter_case));
    cfg_wr_en  <= 1'b0;
    shadow_cfg = c;
  endtask

  // Mostly well-formed strings with random content; the rest is noise.
  task automatic send_random_string();
    int n;
    start_next = 1'b1;
    if ($urandom_range(99) < 80) begin
      send_fill_run();
      case ($urandom_range(3))
        0: if (shadow_cfg.minus_char != CHAR_NONE) send_next(shadow_cfg.minus_char);
        1: if (shadow_cfg.plus_char != CHAR_NONE) send_next(shadow_cfg.plus_char);
        default: ;
      endcase
      send_fill_run();
      n = ($urandom_range(9) == 0) ? $urandom_range(14, 70) : $urandom_range(0, 12);
      repeat (n) send_next(digit_char($urandom_range(active_base() - 1)));
      // terminator; a random byte may still be a digit and keep the parse open
      send_next(CHAR_W'($urandom_range(255)));
      if ($urandom_range(3) == 0)
        repeat ($urandom_range(1, 3)) send_char(CHAR_W'($urandom_range(255)), 1'b0);
    end else begin
      n = $urandom_range(1, 8);
      repeat (n) send_char(CHAR_W'($urandom_range(255)), $urandom_range(3) == 0);
    end
  endtask

  task automatic send_random_strings(int n);
    int goal;
    goal = chars_parsed + n;
    while (chars_parsed < goal) begin
      send_random_string();
      if ($urandom_range(49) == 0) wait_idle();
    end
  endtask

  task automatic test_after_reset();
    // no begin flag needed for the first string after reset
    send_text("5.", 1'b0);
    send_text("Z", 1'b0);     // ignored, parse already done
    send_text("-90!", 1'b1);
    send_text("++", 1'b1);    // second sign ends the parse
    send_text("4", 1'b1);
    send_text("2x", 1'b1);    // begin drops the open parse
    send_text("x", 1'b1);     // empty string
  endtask

  task automatic test_hex_left_fill();
    set_config(make_cfg(16, "-", "+", " ", FM_LEFT, LC_MIXED));
    send_text("  -fF0g", 1'b1);
    send_random_strings(120);
  endtask

  task automatic test_binary_inner_fill();
    set_config(make_cfg(RADIX_MIN, "-", "+", "_", FM_INTERNAL, LC_LOWER));
    send_text("-__1012", 1'b1);
    send_random_strings(120);
  endtask

  task automatic test_letter_cases();
    int lc;
    int rdx;
    for (lc = 0; lc < 8; lc++) begin
      rdx = (lc % 2 == 0) ? RADIX_MAX : 11;
      set_config(make_cfg(rdx, "~", CHAR_NONE, "*", FM_INTERNAL, lc / 2));
      send_text("~*zZaA9/", 1'b1);
      send_random_strings(25);
    end
  endtask

  task automatic test_radix_clamp();
    int   i;
    cfg_t c;
    for (i = 0; i < 4; i++) begin
      case (i)
        0:       c = make_cfg(0, CHAR_NONE, "+", 8'hFF, FM_UNUSED, LC_LOWER);
        1:       c = make_cfg(1, "-", CHAR_NONE, "0", FM_LEFT, LC_MIXED);
        2:       c = make_cfg(37, 8'hFF, 8'hFE, CHAR_NONE, FM_INTERNAL, LC_UNUSED);
        default: c = make_cfg(63, CHAR_NONE, CHAR_NONE, 8'hFF, FM_NO_SKIP, LC_UPPER);
      endcase
      set_config(c);
      send_char(8'hFF, 1'b1);
      send_char("1", 1'b0);
      send_char(8'h00, 1'b0);
      send_random_strings(40);
    end
  endtask

  task automatic test_count_saturation();
    set_config(make_cfg(RADIX_DEC, "-", "+", " ", FM_LEFT, LC_MIXED));
    in_idle_pct   = 0;
    out_stall_pct = 0;
    send_char(" ", 1'b1);
    repeat (SAT_LENGTH) send_char(" ", 1'b0);
    send_text("-7;", 1'b0);
    wait_idle();
    in_idle_pct   = IDLE_PCT;
    out_stall_pct = IDLE_PCT;
  endtask

  task automatic test_random_configs();
    repeat (8) begin
      set_config(make_cfg(
        ($urandom_range(6) == 0) ? $urandom_range(63) : $urandom_range(RADIX_MIN, RADIX_MAX),
        ($urandom_range(4) == 0) ? 0 : $urandom_range(1, 255),
        ($urandom_range(4) == 0) ? 0 : $urandom_range(1, 255),
        ($urandom_range(2) == 0) ? 0 : $urandom_range(1, 255),
        $urandom_range(3), $urandom_range(3)));
      send_random_strings(50);
    end
  endtask

  task automatic test_noise();
    int goal;
    set_config(make_cfg(RADIX_MAX, MINUS_RESET, PLUS_RESET, " ", FM_LEFT, LC_MIXED));
    goal = chars_parsed + 150;
    while (chars_parsed < goal)
      send_char(CHAR_W'($urandom_range(255)), $urandom_range(7) == 0);
  endtask

  always @(posedge clk) begin : result_check
    parse_result_t want;
    out_chan.ready <= ($urandom_range(99) >= out_stall_pct);
    if (!rst && out_chan.valid && out_chan.ready) begin
      if (expected_results.size() == 0) begin
        error_count++;
        if (error_count <= MAX_REPORTS)
          $display("unexpected result: value %h count %0d minus %0b",
                   out_chan.parsed_value, out_chan.consumed_count, out_chan.saw_minus);
      end else begin
        want = expected_results.pop_front();
        if (want.value !== out_chan.parsed_value || want.count !== out_chan.consumed_count ||
            want.minus !== out_chan.saw_minus) begin
          error_count++;
          if (error_count <= MAX_REPORTS)
            $display("mismatch: expected value %h count %0d minus %0b, got %h %0d %0b",
                     want.value, want.count, want.minus, out_chan.parsed_value,
                     out_chan.consumed_count, out_chan.saw_minus);
        end
      end
    end
  end

  initial begin
    rst               <= 1'b1;
    in_chan.valid     <= 1'b0;
    in_chan.char_code <= '0;
    in_chan.begin_req <= 1'b0;
    cfg_wr_en         <= 1'b0;
    cfg_index         <= '0;
    cfg_data          <= '0;
    in_idle_pct   = IDLE_PCT;
    out_stall_pct = IDLE_PCT;
    error_count   = 0;
    chars_parsed  = 0;
    start_next    = 1'b0;
    shadow_cfg = make_cfg(RADIX_RESET, MINUS_RESET, PLUS_RESET, FILL_RESET,
                          FILL_MODE_RESET, LETTER_CASE_RESET);
    restart_parse();
    repeat (4) @(posedge clk);
    rst <= 1'b0;

    test_after_reset();
    test_hex_left_fill();
    test_binary_inner_fill();
    test_letter_cases();
    test_radix_clamp();
    test_count_saturation();
    test_random_configs();
    test_noise();

    wait_idle();
    if (expected_results.size() != 0) error_count++;
    if (error_count == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

  initial begin
    #5000000;
    $display("CHECK FAILED");
    $finish;
  end

endmodule

/* files.f */
src/rsi_pkg.sv
src/rsi_if.sv
src/rsi_char_class.sv
src/radix_string_to_integer_top.sv
sim/testbench.sv
